// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When ante holds, cons must hold in the following cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- sv/ptsp_pkg.sv -----
// ----------------------------------------------------------------------------
// ptsp_pkg
// Types and constants of the pulse train to symbol pair packer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptsp_pkg;

  localparam int unsigned DUR_W      = 21;  // signed input duration
  localparam int unsigned MAG_W      = 20;  // magnitude after saturation
  localparam int unsigned LEN_W      = 15;  // length of one symbol half
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned MAX_CHUNKS = 33;  // chunks taken from one item at most
  localparam int unsigned CNT_W      = 6;

  localparam logic [DUR_W-1:0] DUR_MOST_NEG = {1'b1, {(DUR_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] MAG_SAT      = {MAG_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHUNK,
    ST_FLUSH
  } st_t;

endpackage

`default_nettype wire

// ----- sv/pulse_train_to_symbol_pairs_core.sv -----
// ----------------------------------------------------------------------------
// pulse_train_to_symbol_pairs_core
// Cuts signed pulse durations into chunks of at most MAX_PULSE ticks and
// packs them, two halves at a time, into level/length symbol words.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// in_      in   tdata[20:0] duration (signed), tlast = last of stream
// out_     out  tdata = first_level, first_length, second_level,
//               second_length (low bit up), tlast = end_of_stream
//
// An item is cut into n chunks (at most 33), and a held half is flushed when
// the item is a last one. A single compare/subtract unit on the 20-bit
// magnitude takes off one chunk per cycle. A symbol waiting in the output
// register stalls the chunk loop only when a new symbol is due. Reset (rst_n
// low, synchronous) drops any held half.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pulse_train_to_symbol_pairs_core #(
  parameter int unsigned MAX_PULSE = 32767
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [ptsp_pkg::IN_DATA_W-1:0]     in_tdata,   // [20:0] duration, rest zero
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [ptsp_pkg::OUT_DATA_W-1:0]         out_tdata,  // [0] first_level,
                                                              // [15:1] first_length,
                                                              // [16] second_level,
                                                              // [31:17] second_length
  output logic                                    out_tlast
);

  import ptsp_pkg::*;

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PULSE);

  st_t                  state_r, state_nxt;
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic                 level_r, level_nxt;
  logic                 last_r, last_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 half_pending_r, half_pending_nxt;
  logic                 held_level_r, held_level_nxt;
  logic [LEN_W-1:0]     held_length_r, held_length_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                 out_tlast_r, out_tlast_nxt;

  logic                 in_xfer;
  logic                 slot_free;
  logic                 run_done;
  logic                 final_chunk;
  logic [LEN_W-1:0]     chunk;
  logic [DUR_W-1:0]     raw;
  logic [DUR_W-1:0]     raw_neg;
  logic [MAG_W-1:0]     in_mag;
  logic                 step_en;
  logic                 emit_pair;
  logic                 emit_flush;

  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;

  // magnitude of the incoming duration, most negative pattern saturated
  assign raw     = in_tdata[DUR_W-1:0];
  assign raw_neg = DUR_W'(~raw + 1'b1);
  always_comb begin
    if (raw == DUR_MOST_NEG) begin
      in_mag = MAG_SAT;
    end else if (raw[DUR_W-1]) begin
      in_mag = raw_neg[MAG_W-1:0];
    end else begin
      in_mag = raw[MAG_W-1:0];
    end
  end

  // shared compare/subtract unit
  assign chunk       = (mag_r > {{(MAG_W-LEN_W){1'b0}}, MaxLen}) ? MaxLen : mag_r[LEN_W-1:0];
  assign run_done    = (mag_r == '0) || (cnt_r == CNT_W'(MAX_CHUNKS));
  assign final_chunk = (mag_r <= {{(MAG_W-LEN_W){1'b0}}, MaxLen}) ||
                       (cnt_r == CNT_W'(MAX_CHUNKS - 1));

  // sequencer outputs
  always_comb begin
    in_tready  = 1'b0;
    step_en    = 1'b0;
    emit_pair  = 1'b0;
    emit_flush = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_CHUNK: begin
        if (!run_done) begin
          if (!half_pending_r) begin
            step_en = 1'b1;
          end else if (slot_free) begin
            step_en   = 1'b1;
            emit_pair = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        emit_flush = slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_CHUNK;
      end
      ST_CHUNK: begin
        if (run_done) begin
          state_nxt = (last_r && half_pending_r) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (emit_flush) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_comb begin
    mag_nxt          = mag_r;
    level_nxt        = level_r;
    last_nxt         = last_r;
    cnt_nxt          = cnt_r;
    half_pending_nxt = half_pending_r;
    held_level_nxt   = held_level_r;
    held_length_nxt  = held_length_r;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;
    out_tdata_nxt    = out_tdata_r;
    out_tlast_nxt    = out_tlast_r;

    if (in_xfer) begin
      mag_nxt   = in_mag;
      level_nxt = !raw[DUR_W-1];
      last_nxt  = in_tlast;
      cnt_nxt   = '0;
    end

    if (step_en) begin
      mag_nxt = mag_r - {{(MAG_W-LEN_W){1'b0}}, chunk};
      cnt_nxt = cnt_r + 1'b1;
      if (!half_pending_r) begin
        half_pending_nxt = 1'b1;
        held_level_nxt   = level_r;
        held_length_nxt  = chunk;
      end else begin
        half_pending_nxt = 1'b0;
      end
    end

    if (emit_pair) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {chunk, level_r, held_length_r, held_level_r};
      out_tlast_nxt  = last_r && final_chunk;
    end

    if (emit_flush) begin
      half_pending_nxt = 1'b0;
      out_tvalid_nxt   = 1'b1;
      out_tdata_nxt    = {{LEN_W{1'b0}}, 1'b0, held_length_r, held_level_r};
      out_tlast_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      half_pending_r <= 1'b0;
      held_level_r   <= 1'b0;
      held_length_r  <= '0;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      half_pending_r <= half_pending_nxt;
      held_level_r   <= held_level_nxt;
      held_length_r  <= held_length_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    level_r     <= level_nxt;
    last_r      <= last_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `ASSERT_ALWAYS(a_flush_has_half, (state_r != ST_FLUSH) || half_pending_r, "flush without held half")
  `ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(MAX_CHUNKS), "chunk count past limit")
  `ASSERT_ALWAYS(a_unpaired_is_end, !out_tvalid_r || (out_tdata_r[OUT_DATA_W-1:LEN_W+2] != '0) || out_tlast_r, "unpaired symbol without end marker")
  `ASSERT_NEXT(a_accept_starts_run, in_xfer, state_r == ST_CHUNK, "accepted item did not start chunking")
  `ASSERT_ALWAYS(a_no_double_emit, !(emit_pair && emit_flush), "pair and flush in one cycle")

endmodule

`default_nettype wire

// ----- test/ptsp_symbol_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ptsp_symbol_checker
// Watches both stream channels of the pulse packer, predicts the symbol words
// that each accepted duration produces and compares every output transfer
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ptsp_symbol_checker #(
  parameter int unsigned MAX_PULSE = 32767
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ptsp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ptsp_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  output int                              mismatch_count,
  output int                              symbols_due,
  output int                              symbols_checked,
  output int                              streams_closed
);

  import ptsp_pkg::*;

  typedef struct packed {
    logic             first_level;
    logic [LEN_W-1:0] first_length;
    logic             second_level;
    logic [LEN_W-1:0] second_length;
    logic             end_of_stream;
  } symbol_t;

  symbol_t          expected_symbols[$];
  logic             half_pending;
  logic             held_level;
  logic [LEN_W-1:0] held_length;

  // append one predicted symbol behind the outstanding ones
  function automatic void queue_symbol(input symbol_t sym);
    expected_symbols.insert(expected_symbols.size(), sym);
  endfunction

  always @(posedge clk) begin : track
    symbol_t          got;
    symbol_t          want;
    symbol_t          tail;
    logic [DUR_W-1:0] dur;
    logic [MAG_W:0]   mag;
    logic [LEN_W-1:0] chunk;
    logic             level;
    int               n_chunks;
    int               n_made;
    int               last_idx;

    if (!rst_n) begin
      expected_symbols.delete();
      half_pending    = 1'b0;
      held_level      = 1'b0;
      held_length     = '0;
      mismatch_count  = 0;
      symbols_checked = 0;
      streams_closed  = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[15:1], out_tdata[16], out_tdata[31:17], out_tlast};
        if (expected_symbols.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected symbol, expected none, got %b/%0d %b/%0d eos %b",
                   $realtime, got.first_level, got.first_length, got.second_level,
                   got.second_length, got.end_of_stream);
        end else begin
          want = expected_symbols.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: symbol mismatch, expected %b/%0d %b/%0d eos %b, got %b/%0d %b/%0d eos %b",
                     $realtime, want.first_level, want.first_length, want.second_level,
                     want.second_length, want.end_of_stream, got.first_level,
                     got.first_length, got.second_level, got.second_length,
                     got.end_of_stream);
          end
          if (got.end_of_stream === 1'b1) streams_closed++;
        end
        symbols_checked++;
      end

      if (in_tvalid && in_tready) begin
        dur      = in_tdata[DUR_W-1:0];
        level    = ~dur[DUR_W-1];
        mag      = dur[DUR_W-1] ? (~dur + 1'b1) : dur;
        n_chunks = 0;
        n_made   = 0;
        // saturate the most negative pattern
        if (mag > MAG_SAT) mag = MAG_SAT;
        while (mag != 0 && n_chunks < MAX_CHUNKS) begin
          chunk = (mag > MAX_PULSE) ? LEN_W'(MAX_PULSE) : mag[LEN_W-1:0];
          mag   = mag - chunk;
          n_chunks++;
          if (!half_pending) begin
            held_level   = level;
            held_length  = chunk;
            half_pending = 1'b1;
          end else begin
            queue_symbol({held_level, held_length, level, chunk, 1'b0});
            half_pending = 1'b0;
            n_made++;
          end
        end
        if (in_tlast) begin
          if (half_pending) begin
            queue_symbol({held_level, held_length, 1'b0, {LEN_W{1'b0}}, 1'b0});
            half_pending = 1'b0;
            n_made++;
          end
          // mark the final symbol of this item, if it made any
          if (n_made > 0) begin
            last_idx           = expected_symbols.size() - 1;
            tail               = expected_symbols[last_idx];
            tail.end_of_stream = 1'b1;
            expected_symbols[last_idx] = tail;
          end
        end
      end
    end
    symbols_due = expected_symbols.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the pulse train to symbol pair packer: directed corner
// durations, then random streams under three mixes of sender and receiver
// idling. The checker beside the block predicts and compares the symbols.
// ----------------------------------------------------------------------------
module tb_top;
  import ptsp_pkg::*;

  localparam int unsigned MAX_PULSE   = 32767;
  localparam int          STALL_LIMIT = 2000;
  localparam int          ITEMS_PER_PHASE = 140;
  localparam int          DRAIN_CYCLES = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [20:0] duration, rest zero
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [0] first_level, [15:1] first_length,
                                     // [16] second_level, [31:17] second_length
  logic                  out_tlast;

  int mismatch_count;
  int symbols_due;
  int symbols_checked;
  int streams_closed;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;
  int stall_cycles;

  pulse_train_to_symbol_pairs_core #(
    .MAX_PULSE(MAX_PULSE)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  ptsp_symbol_checker #(
    .MAX_PULSE(MAX_PULSE)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .symbols_due    (symbols_due),
    .symbols_checked(symbols_checked),
    .streams_closed (streams_closed)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // end the run when no transfer happens on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d symbols outstanding",
                 $realtime, STALL_LIMIT, symbols_due);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_pulse(input logic [DUR_W-1:0] dur, input logic last_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W-DUR_W){1'b0}}, dur};
    in_tlast  <= last_in;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // hold the sender off until every predicted symbol has arrived
  task automatic drain_symbols();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (symbols_due != 0) @(posedge clk);
  endtask

  function automatic logic [DUR_W-1:0] random_duration();
    int unsigned pick;
    int          mag;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 13) return DUR_W'($urandom);
    if (pick < 15) return DUR_MOST_NEG;
    if (pick < 68) mag = $urandom_range(MAX_PULSE, 1);
    else if (pick < 78) mag = $urandom_range(32, 1) * MAX_PULSE + $urandom_range(2) - 1;
    else if (pick < 94) mag = $urandom_range(200000, 1);
    else mag = $urandom_range(1048575, 1);
    return $urandom_range(1) ? DUR_W'(mag) : DUR_W'(-mag);
  endfunction

  initial begin
    int corner_dur[$];
    bit corner_last[$];

    corner_dur  = '{0, 0, 1, 0, -1, 32767, -32767, 32768, 5, 1048575, -1048576, -1048575,
                    100, 0, -20, 0, 1048575, 65534, -65535, 32766};
    corner_last = '{0, 1, 0, 0, 0, 0, 1, 0, 1, 0, 0, 1,
                    0, 1, 1, 1, 1, 0, 0, 1};
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    out_tready    = 1'b0;
    items_sent    = 0;
    send_idle_pct = 24;
    recv_idle_pct = 58;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (corner_dur[i]) send_pulse(DUR_W'(corner_dur[i]), corner_last[i]);
    drain_symbols();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 58 : 0;
      recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 24 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_pulse(random_duration(), $urandom_range(7) == 0);
      end
      drain_symbols();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d durations: directed corners, then random streams under three idling mixes.",
             items_sent);
    $display("Compared %0d symbol words, %0d of them closing a stream.",
             symbols_checked, streams_closed);
    if (mismatch_count == 0 && symbols_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ptsp_pkg.sv
sv/pulse_train_to_symbol_pairs_core.sv
test/ptsp_symbol_checker.sv
test/tb_top.sv
